@@ design/bpa_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bpa_pkg
// Shared types and codes of the bitmap page allocator: command, status and
// request kind codes, back-end state and back-end status bundle.
// ============================================================================
package bpa_pkg;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_MARK  = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    localparam int unsigned PAGE_SHIFT = 12;
    localparam int unsigned WORD_BITS  = 64;

    // Classified request kind, as it travels through the queue
    typedef enum logic [1:0] {
        K_ALLOC = 2'd0,
        K_FREE  = 2'd1,
        K_MARK  = 2'd2,
        K_BAD   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_RECOUNT,
        S_IDLE,
        S_MOD,
        S_SCAN
    } t_bk_state;

    typedef struct packed {
        logic busy;
    } t_bk_stat;

endpackage

@@ design/bpa_front.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bpa_front
// Accepts requests and classifies them: address alignment, null and range
// checks, then pushes kind and page index into the request queue.
// ============================================================================
module bpa_front #(
    parameter int unsigned PG_W  = 16,
    parameter int unsigned CNT_W = 17
) (
    input  logic               i_tvalid,
    output logic               o_tready,
    input  logic [1:0]         i_command,
    input  logic [47:0]        i_phys_address,
    input  logic [CNT_W-1:0]   i_n,
    input  bpa_pkg::t_bk_stat  i_stat,
    input  logic               i_q_full,
    output logic               o_push,
    output bpa_pkg::t_kind     o_kind,
    output logic [PG_W-1:0]    o_page
);
    import bpa_pkg::*;

    logic        aligned;
    logic        in_rng;
    logic        nonzero;
    logic [35:0] page36;

    // Take requests while the queue has room and no sweep runs
    assign o_tready = !i_q_full && !i_stat.busy;
    assign o_push   = i_tvalid && o_tready;

    assign page36  = i_phys_address[47:PAGE_SHIFT];
    assign aligned = (i_phys_address[PAGE_SHIFT-1:0] == '0);
    assign nonzero = (i_phys_address != '0);
    assign in_rng  = (page36 < 36'(i_n));
    assign o_page  = PG_W'(page36);

    // Classify the command
    always_comb begin
        case (i_command)
            CMD_ALLOC: o_kind = K_ALLOC;
            CMD_FREE:  o_kind = (nonzero && aligned && in_rng) ? K_FREE : K_BAD;
            CMD_MARK:  o_kind = (aligned && in_rng) ? K_MARK : K_BAD;
            default:   o_kind = K_BAD;
        endcase
    end

endmodule

@@ design/bpa_fifo.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bpa_fifo
// Two-entry request queue between the front and the back end.
// ============================================================================
module bpa_fifo #(
    parameter int unsigned W = 18
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    // Store and advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_data;
                r_wp        <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

@@ design/bpa_back.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bpa_back
// Executes requests on the used-page bitmap memory: first-fit word scan for
// alloc, read-modify-write for free and mark, clearing pass after reset and
// used-count recount after a page count change.
// ============================================================================
module bpa_back #(
    parameter int unsigned PG_W      = 16,
    parameter int unsigned CNT_W     = 17,
    parameter int unsigned WA_W      = 10,
    parameter int unsigned MAP_WORDS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [CNT_W-1:0]   i_n,
    input  logic               i_cfg_wr,
    input  logic               i_q_valid,
    input  bpa_pkg::t_kind     i_q_kind,
    input  logic [PG_W-1:0]    i_q_page,
    output logic               o_q_pop,
    output bpa_pkg::t_bk_stat  o_stat,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [27:0]        o_page_address,
    output logic [1:0]         o_status,
    output logic [16:0]        o_free_pages
);
    import bpa_pkg::*;

    localparam int unsigned IDX_W  = WA_W + 6;
    localparam int unsigned BASE_W = IDX_W + 1;

    logic [63:0] r_map [MAP_WORDS];

    t_bk_state        r_state, n_state;
    logic [WA_W-1:0]  r_clr, n_clr;
    logic             r_rc_pend, n_rc_pend;
    logic [CNT_W-1:0] r_used, n_used;
    logic [WA_W-1:0]  r_hint, n_hint;
    t_kind            r_op_kind, n_op_kind;
    logic [PG_W-1:0]  r_op_page, n_op_page;
    logic [WA_W-1:0]  r_scan_w, n_scan_w;
    logic [WA_W:0]    r_rc_iss, n_rc_iss;
    logic             r_v1, n_v1;
    logic [WA_W-1:0]  r_w1, n_w1;
    logic             r_v2, n_v2;
    logic [6:0]       r_pc, n_pc;
    logic             r_out_valid, n_out_valid;
    logic [27:0]      r_out_pa, n_out_pa;
    logic [1:0]       r_out_st, n_out_st;
    logic [16:0]      r_out_free, n_out_free;
    logic [63:0]      r_rd_data;

    logic             rd_en;
    logic [WA_W-1:0]  rd_addr;
    logic             wr_en;
    logic [WA_W-1:0]  wr_addr;
    logic [63:0]      wr_data;

    logic [WA_W-1:0]  op_word;
    logic             op_bit;
    logic [5:0]       zero_pos;
    logic             zero_any;
    logic [BASE_W-1:0] scan_idx;
    logic [BASE_W-1:0] next_base;
    logic [BASE_W-1:0] n_ext;

    // Pages of word w that lie below the managed count
    function automatic logic [63:0] word_mask(input logic [WA_W-1:0] w,
                                              input logic [CNT_W-1:0] n);
        logic [BASE_W-1:0] base;
        logic [BASE_W-1:0] nn;
        logic [BASE_W-1:0] rem;
        base = BASE_W'(w) << 6;
        nn   = BASE_W'(n);
        rem  = nn - base;
        if (nn <= base) begin
            return 64'd0;
        end else if (rem >= BASE_W'(WORD_BITS)) begin
            return '1;
        end else begin
            return (64'd1 << rem[5:0]) - 64'd1;
        end
    endfunction

    function automatic logic [16:0] free_of(input logic [CNT_W-1:0] used,
                                            input logic [CNT_W-1:0] n);
        return (used <= n) ? 17'(n - used) : 17'd0;
    endfunction

    assign o_stat.busy    = (r_state == S_CLEAR) || (r_state == S_RECOUNT) || r_rc_pend;
    assign o_m_tvalid     = r_out_valid;
    assign o_page_address = r_out_pa;
    assign o_status       = r_out_st;
    assign o_free_pages   = r_out_free;

    assign op_word   = WA_W'(r_op_page >> 6);
    assign op_bit    = r_rd_data[r_op_page[5:0]];
    assign n_ext     = BASE_W'(i_n);
    assign scan_idx  = BASE_W'({r_scan_w, zero_pos});
    assign next_base = (BASE_W'(r_scan_w) + BASE_W'(1)) << 6;

    // Lowest free page in the word just read
    always_comb begin
        zero_pos = 6'd0;
        zero_any = 1'b0;
        for (int b = 63; b >= 0; b--) begin
            if (!r_rd_data[b]) begin
                zero_pos = 6'(b);
                zero_any = 1'b1;
            end
        end
    end

    // Bitmap memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_map[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_map[rd_addr];
        end
    end

    // Next state and datapath
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_rc_pend   = r_rc_pend;
        n_used      = r_used;
        n_hint      = r_hint;
        n_op_kind   = r_op_kind;
        n_op_page   = r_op_page;
        n_scan_w    = r_scan_w;
        n_rc_iss    = r_rc_iss;
        n_v1        = 1'b0;
        n_w1        = r_w1;
        n_v2        = 1'b0;
        n_pc        = r_pc;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_pa    = r_out_pa;
        n_out_st    = r_out_st;
        n_out_free  = r_out_free;
        o_q_pop     = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;

        case (r_state)
            S_CLEAR: begin
                // Sweep the map: page 0 reserved, all else free
                wr_en   = 1'b1;
                wr_addr = r_clr;
                wr_data = (r_clr == '0) ? 64'd1 : 64'd0;
                if (r_clr == WA_W'(MAP_WORDS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + WA_W'(1);
                end
            end

            S_RECOUNT: begin
                // Issue reads, count masked bits, accumulate
                if (r_rc_iss < (WA_W + 1)'(MAP_WORDS)) begin
                    rd_en    = 1'b1;
                    rd_addr  = WA_W'(r_rc_iss);
                    n_rc_iss = r_rc_iss + (WA_W + 1)'(1);
                    n_v1     = 1'b1;
                    n_w1     = WA_W'(r_rc_iss);
                end
                if (r_v1) begin
                    n_pc = 7'($countones(r_rd_data & word_mask(r_w1, i_n)));
                    n_v2 = 1'b1;
                end
                if (r_v2) begin
                    n_used = r_used + CNT_W'(r_pc);
                end
                if (r_rc_iss == (WA_W + 1)'(MAP_WORDS) && !r_v1 && !r_v2) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (r_rc_pend) begin
                    n_rc_pend = 1'b0;
                    n_used    = '0;
                    n_rc_iss  = '0;
                    n_state   = S_RECOUNT;
                end else if (i_q_valid && !r_out_valid) begin
                    o_q_pop   = 1'b1;
                    n_op_kind = i_q_kind;
                    n_op_page = i_q_page;
                    case (i_q_kind)
                        K_FREE, K_MARK: begin
                            rd_en   = 1'b1;
                            rd_addr = WA_W'(i_q_page >> 6);
                            n_state = S_MOD;
                        end
                        K_ALLOC: begin
                            if (i_n == '0) begin
                                n_out_valid = 1'b1;
                                n_out_pa    = '0;
                                n_out_st    = ST_NONE;
                                n_out_free  = free_of(r_used, i_n);
                            end else begin
                                rd_en    = 1'b1;
                                rd_addr  = r_hint;
                                n_scan_w = r_hint;
                                n_state  = S_SCAN;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_out_pa    = '0;
                            n_out_st    = ST_BAD;
                            n_out_free  = free_of(r_used, i_n);
                        end
                    endcase
                end
            end

            S_MOD: begin
                // Read-modify-write of one page bit
                n_out_valid = 1'b1;
                n_out_pa    = '0;
                n_out_st    = ST_OK;
                n_state     = S_IDLE;
                wr_addr     = op_word;
                if (r_op_kind == K_FREE) begin
                    if (op_bit) begin
                        wr_en   = 1'b1;
                        wr_data = r_rd_data & ~(64'd1 << r_op_page[5:0]);
                        if (r_used != '0) begin
                            n_used = r_used - CNT_W'(1);
                        end
                        if (op_word < r_hint) begin
                            n_hint = op_word;
                        end
                    end else begin
                        n_out_st = ST_BAD;
                    end
                end else if (!op_bit) begin
                    wr_en   = 1'b1;
                    wr_data = r_rd_data | (64'd1 << r_op_page[5:0]);
                    n_used  = r_used + CNT_W'(1);
                end
                n_out_free = free_of(n_used, i_n);
            end

            S_SCAN: begin
                // First-fit scan, one word per cycle from the hint
                if (zero_any) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_hint      = r_scan_w;
                    if (scan_idx < n_ext) begin
                        wr_en      = 1'b1;
                        wr_addr    = r_scan_w;
                        wr_data    = r_rd_data | (64'd1 << zero_pos);
                        n_used     = r_used + CNT_W'(1);
                        n_out_pa   = 28'(scan_idx) << PAGE_SHIFT;
                        n_out_st   = ST_OK;
                    end else begin
                        n_out_pa = '0;
                        n_out_st = ST_NONE;
                    end
                    n_out_free = free_of(n_used, i_n);
                end else if (next_base >= n_ext ||
                             r_scan_w == WA_W'(MAP_WORDS - 1)) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_out_pa    = '0;
                    n_out_st    = ST_NONE;
                    n_out_free  = free_of(r_used, i_n);
                    if (r_scan_w != WA_W'(MAP_WORDS - 1)) begin
                        n_hint = r_scan_w + WA_W'(1);
                    end
                end else begin
                    rd_en    = 1'b1;
                    rd_addr  = r_scan_w + WA_W'(1);
                    n_scan_w = r_scan_w + WA_W'(1);
                    n_hint   = r_scan_w + WA_W'(1);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_wr) begin
            n_rc_pend = 1'b1;
        end
    end

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_rc_pend   <= 1'b0;
            r_used      <= CNT_W'(1);
            r_hint      <= '0;
            r_rc_iss    <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_rc_pend   <= n_rc_pend;
            r_used      <= n_used;
            r_hint      <= n_hint;
            r_rc_iss    <= n_rc_iss;
            r_v1        <= n_v1;
            r_v2        <= n_v2;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op_kind  <= n_op_kind;
        r_op_page  <= n_op_page;
        r_scan_w   <= n_scan_w;
        r_w1       <= n_w1;
        r_pc       <= n_pc;
        r_out_pa   <= n_out_pa;
        r_out_st   <= n_out_st;
        r_out_free <= n_out_free;
    end

endmodule

@@ design/bitmap_page_allocator.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bitmap_page_allocator
// First-fit physical page allocator with one used bit per 4096-byte page.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------
//  s        | in        | s_tvalid / s_tready  | tdata phys_address, tuser cmd
//  m        | out       | m_tvalid / m_tready  | tdata page_address, free_pages;
//           |           |                      | tuser status
//  apb      | in        | psel/penable/pready  | page_count at byte address 0
//
// A bad request is answered from the idle state; free and mark read the word,
// then write it back; alloc scans bitmap words from the lowest possibly free word.
// After reset a clearing pass runs; after a page count write a recount runs;
// s_tready is low during both.
// A two-entry request queue lets requests arrive while a result waits on m.
// ============================================================================
module bitmap_page_allocator #(
    parameter int unsigned MAX_PAGES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // [47:0] phys_address
    input  logic [1:0]  i_s_tuser,   // [1:0] command
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // [27:0] page_address, [44:28] free_pages, zero pad
    output logic [1:0]  o_m_tuser,   // [1:0] status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bpa_pkg::*;

    localparam int unsigned PG_W      = $clog2(MAX_PAGES);
    localparam int unsigned CNT_W     = PG_W + 1;
    localparam int unsigned MAP_WORDS = (MAX_PAGES + 63) / 64;
    localparam int unsigned WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int unsigned CMP_W     = (CNT_W > 17) ? CNT_W : 17;

    logic [16:0]      r_cfg;
    logic             cfg_wr;
    logic [CMP_W-1:0] cfg_ext;
    logic [CNT_W-1:0] n_eff;

    t_bk_stat         stat;
    logic             q_full;
    logic             q_push;
    t_kind            f_kind;
    logic [PG_W-1:0]  f_page;
    logic             q_valid;
    logic             q_pop;
    logic [PG_W+1:0]  q_data;
    logic [27:0]      page_address;
    logic [1:0]       status;
    logic [16:0]      free_pages;

    // Configuration register
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata  = (paddr[2] == 1'b0) ? 32'(r_cfg) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= 17'd65536;
        end else if (cfg_wr) begin
            r_cfg <= pwdata[16:0];
        end
    end

    // Effective page count
    assign cfg_ext = CMP_W'(r_cfg);
    assign n_eff   = (cfg_ext > CMP_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : CNT_W'(cfg_ext);

    bpa_front #(
        .PG_W  (PG_W),
        .CNT_W (CNT_W)
    ) u_front (
        .i_tvalid       (i_s_tvalid),
        .o_tready       (o_s_tready),
        .i_command      (i_s_tuser),
        .i_phys_address (i_s_tdata),
        .i_n            (n_eff),
        .i_stat         (stat),
        .i_q_full       (q_full),
        .o_push         (q_push),
        .o_kind         (f_kind),
        .o_page         (f_page)
    );

    bpa_fifo #(
        .W (PG_W + 2)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({f_kind, f_page}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    bpa_back #(
        .PG_W      (PG_W),
        .CNT_W     (CNT_W),
        .WA_W      (WA_W),
        .MAP_WORDS (MAP_WORDS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_n            (n_eff),
        .i_cfg_wr       (cfg_wr),
        .i_q_valid      (q_valid),
        .i_q_kind       (t_kind'(q_data[PG_W+1:PG_W])),
        .i_q_page       (q_data[PG_W-1:0]),
        .o_q_pop        (q_pop),
        .o_stat         (stat),
        .o_m_tvalid     (o_m_tvalid),
        .i_m_tready     (i_m_tready),
        .o_page_address (page_address),
        .o_status       (status),
        .o_free_pages   (free_pages)
    );

    // Pack the result
    assign o_m_tdata = {3'd0, free_pages, page_address};
    assign o_m_tuser = status;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Exercises the bitmap page allocator with directed and random alloc, free,
// mark and unknown requests under several page counts. A scoreboard keeps its
// own used bitmap and checks every result field by field.
// ============================================================================
module testbench;
    import bpa_pkg::*;

    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam logic [2:0] REG_PAGE_COUNT = 3'd0;
    localparam int unsigned MAP_PAGES = 65536;

    typedef struct {
        logic [27:0] page_address;
        logic [1:0]  status;
        logic [16:0] free_pages;
    } t_alloc_result;

    // Scoreboard: shadow bitmap, used counter and queue of expected results
    class page_ledger;
        bit            used [MAP_PAGES];
        int unsigned   used_total;
        int unsigned   page_count;
        t_alloc_result expected_q [$];
        int unsigned   errors;

        function new();
            foreach (used[i]) used[i] = 0;
            used[0] = 1;
            page_count = MAP_PAGES;
            used_total = 1;
            errors = 0;
        endfunction

        // Clamp the count and recount used pages below it
        function void set_count(logic [16:0] value);
            page_count = (value > MAP_PAGES) ? MAP_PAGES : value;
            used_total = 0;
            for (int i = 0; i < page_count; i++)
                if (used[i]) used_total++;
        endfunction

        function void note_request(logic [1:0] cmd, logic [47:0] addr);
            t_alloc_result r;
            logic [35:0] page;
            bit aligned;
            page = addr[47:12];
            aligned = (addr[11:0] == 0);
            r.page_address = '0;
            r.status = ST_BAD;
            if (cmd == CMD_ALLOC) begin
                r.status = ST_NONE;
                for (int i = 0; i < page_count; i++) begin
                    if (!used[i]) begin
                        used[i] = 1;
                        used_total++;
                        r.page_address = 28'(i << PAGE_SHIFT);
                        r.status = ST_OK;
                        break;
                    end
                end
            end else if (cmd == CMD_FREE) begin
                if (addr != 0 && aligned && page < page_count && used[page]) begin
                    used[page] = 0;
                    if (used_total > 0) used_total--;
                    r.status = ST_OK;
                end
            end else if (cmd == CMD_MARK) begin
                if (aligned && page < page_count) begin
                    if (!used[page]) begin
                        used[page] = 1;
                        used_total++;
                    end
                    r.status = ST_OK;
                end
            end
            r.free_pages = (used_total <= page_count) ? 17'(page_count - used_total) : 17'd0;
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [27:0] pa, logic [1:0] st, logic [16:0] fp);
            t_alloc_result e;
            if (expected_q.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (pa !== e.page_address) begin
                $error("page_address expected %h got %h", e.page_address, pa);
                errors++;
            end
            if (st !== e.status) begin
                $error("status expected %0d got %0d", e.status, st);
                errors++;
            end
            if (fp !== e.free_pages) begin
                $error("free_pages expected %0d got %0d", e.free_pages, fp);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [47:0] i_s_tdata;   // [47:0] phys_address
    logic [1:0]  i_s_tuser;   // [1:0] command
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [47:0] o_m_tdata;   // [27:0] page_address, [44:28] free_pages, zero pad
    logic [1:0]  o_m_tuser;   // [1:0] status
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    page_ledger  ledger = new();
    int unsigned results_seen = 0;

    bitmap_page_allocator DUT (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop if the run hangs
    initial begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

    // Check results first, then note new requests
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            ledger.check_result(o_m_tdata[27:0], o_m_tuser, o_m_tdata[44:28]);
            results_seen++;
        end
        if (i_rst_n && i_s_tvalid && o_s_tready)
            ledger.note_request(i_s_tuser, i_s_tdata);
    end

    // Receiver: random stalls, quiet stretches, one long hold-off
    initial begin
        int unsigned gap;
        bit held;
        held = 0;
        i_m_tready = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && results_seen >= 300) begin
                held = 1;
                i_m_tready <= 0;
                repeat (400) @(negedge i_clk);
            end
            gap = ((results_seen / 64) % 3 == 1) ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
                i_m_tready <= 0;
                repeat (gap) @(negedge i_clk);
            end
            i_m_tready <= 1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    // Send one request after a random gap, hold until accepted
    task automatic send_request(logic [1:0] cmd, logic [47:0] addr);
        int unsigned gap;
        gap = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 15);
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= addr;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Drain outstanding results, then write the page count over APB
    task automatic write_page_count(logic [16:0] value);
        @(negedge i_clk);
        i_s_tvalid <= 0;
        while (ledger.expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1;
        pwrite  <= 1;
        paddr   <= REG_PAGE_COUNT;
        pwdata  <= {15'd0, value};
        penable <= 0;
        @(negedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        ledger.set_count(value);
        @(negedge i_clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
    endtask

    function automatic logic [47:0] pick_address(int unsigned span);
        int unsigned sel;
        logic [47:0] a;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            a = 48'({$urandom, $urandom});
        end else if (sel == 1) begin
            a = 48'({$urandom_range(0, span + 3), 12'd0});
            a[11:0] = 12'($urandom_range(1, 4095));
        end else begin
            a = 48'({$urandom_range(0, span + 3), 12'd0});
        end
        return a;
    endfunction

    // Random mix biased toward valid pages of the current range
    task automatic random_requests(int unsigned n, int unsigned span);
        int unsigned r;
        logic [1:0] cmd;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 40)      cmd = CMD_ALLOC;
            else if (r < 75) cmd = CMD_FREE;
            else if (r < 95) cmd = CMD_MARK;
            else             cmd = CMD_UNKNOWN;
            send_request(cmd, pick_address(span));
        end
    endtask

    initial begin
        i_rst_n    = 0;
        i_s_tvalid = 0;
        i_s_tdata  = '0;
        i_s_tuser  = CMD_ALLOC;
        psel       = 0;
        penable    = 0;
        pwrite     = 0;
        paddr      = REG_PAGE_COUNT;
        pwdata     = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: reset count, extremes and special cases
        send_request(CMD_ALLOC, 48'd0);
        send_request(CMD_ALLOC, 48'hFFFF_FFFF_FFFF);
        send_request(CMD_FREE, 48'd0);
        send_request(CMD_FREE, 48'h1001);
        send_request(CMD_FREE, 48'h1000);
        send_request(CMD_FREE, 48'h1000);
        send_request(CMD_FREE, 48'hFFFF_FFFF_F000);
        send_request(CMD_FREE, 48'h0FFF_F000);
        send_request(CMD_MARK, 48'd0);
        send_request(CMD_MARK, 48'h2000);
        send_request(CMD_MARK, 48'h2000);
        send_request(CMD_MARK, 48'h2FFF);
        send_request(CMD_MARK, 48'h0FFF_F000);
        send_request(CMD_MARK, 48'h1000_0000);
        send_request(CMD_UNKNOWN, 48'h3000);
        send_request(CMD_ALLOC, 48'd0);
        send_request(CMD_FREE, 48'h0FFF_F000);

        write_page_count(17'd100);
        random_requests(330, 100);
        write_page_count(17'd1);
        send_request(CMD_ALLOC, 48'd0);
        send_request(CMD_FREE, 48'h1000);
        random_requests(80, 1);
        write_page_count(17'd0);
        send_request(CMD_ALLOC, 48'd0);
        send_request(CMD_MARK, 48'd0);
        send_request(CMD_FREE, 48'd0);
        random_requests(40, 2);
        write_page_count(17'h1FFFF);
        random_requests(300, 400);
        write_page_count(17'd65536);
        random_requests(100, 65536);
        write_page_count(17'd200);
        random_requests(180, 200);

        @(negedge i_clk);
        i_s_tvalid <= 0;
        while (ledger.expected_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (ledger.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
